>>> sv/first_fit_page_allocator_defines.svh
// assertion macros used by the checker file
// no dependencies
`ifndef FIRST_FIT_PAGE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FFPA_ASSERT_IMP(label, clk_s, rst_n_s, pre, post) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (pre) |-> (post)) \
		else $error("ffpa check failed");

// implication checked in the next cycle
`define FFPA_ASSERT_NEXT(label, clk_s, rst_n_s, pre, post) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (pre) |=> (post)) \
		else $error("ffpa check failed");

`endif

>>> sv/ffpa_pkg.sv
// shared types and constants for the first-fit page allocator
// no dependencies
package ffpa_pkg;

	localparam int unsigned LIST_ENTRIES_DEF = 64;
	localparam int unsigned PAGE_BYTES_DEF   = 4096;

	localparam int unsigned PAGE_W = 21;
	localparam int unsigned LEN_W  = 21;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_ZERO    = 3'd1,
		ST_NOFIT   = 3'd2,
		ST_UNKNOWN = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	localparam logic CFG_FIRST = 1'b0;
	localparam logic CFG_END   = 1'b1;

	typedef struct packed {
		logic [PAGE_W-1:0] start;
		logic [LEN_W-1:0]  len;
	} extent_t;

	// command sent down a chain of cells for one step
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_INIT,
		CMD_REMOVE,
		CMD_INSERT,
		CMD_APPEND,
		CMD_UPDATE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [12:0] idx;
		extent_t ext;
	} chain_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_APPLY,
		S_OUT
	} state_t;

endpackage

>>> sv/ffpa_cell.sv
// one storage cell of an extent chain
// depends on ffpa_pkg
module ffpa_cell
	import ffpa_pkg::*;
#(
	parameter int unsigned IDX_W = 6,
	parameter int unsigned MY_IDX = 0
) (
	input  logic       clk,
	input  chain_cmd_t cmd,
	input  extent_t    from_next,
	input  extent_t    from_prev,
	output extent_t    ext
);

	localparam logic [IDX_W-1:0] ME = IDX_W'(MY_IDX);

	extent_t ext_q;

	always_ff @(posedge clk) begin
		case (cmd.kind)
			CMD_INIT: begin
				if (ME == '0) ext_q <= cmd.ext;
			end
			CMD_REMOVE: begin
				if (ME >= cmd.idx[IDX_W-1:0]) ext_q <= from_next;
			end
			CMD_INSERT: begin
				if (ME == cmd.idx[IDX_W-1:0]) ext_q <= cmd.ext;
				else if (ME > cmd.idx[IDX_W-1:0]) ext_q <= from_prev;
			end
			CMD_APPEND, CMD_UPDATE: begin
				if (ME == cmd.idx[IDX_W-1:0]) ext_q <= cmd.ext;
			end
			default: ;
		endcase
	end

	assign ext = ext_q;

endmodule

>>> sv/ffpa_chain.sv
// row of extent cells with a serial read port and shift moves
// depends on ffpa_pkg and ffpa_cell
module ffpa_chain
	import ffpa_pkg::*;
#(
	parameter int unsigned ENTRIES = LIST_ENTRIES_DEF,
	parameter int unsigned IDX_W = $clog2(ENTRIES)
) (
	input  logic             clk,
	input  chain_cmd_t       cmd,
	input  logic [IDX_W-1:0] rd_idx,
	output extent_t          rd_ext
);

	extent_t cells [ENTRIES];

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		extent_t nx;
		extent_t pv;
		if (g == ENTRIES - 1) begin : g_last
			assign nx = cells[g];
		end else begin : g_mid
			assign nx = cells[g+1];
		end
		if (g == 0) begin : g_first
			assign pv = cells[g];
		end else begin : g_rest
			assign pv = cells[g-1];
		end
		ffpa_cell #(.IDX_W(IDX_W), .MY_IDX(g)) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.from_next (nx),
			.from_prev (pv),
			.ext       (cells[g])
		);
	end

	assign rd_ext = cells[rd_idx];

endmodule

>>> sv/first_fit_page_allocator.sv
// first-fit page allocator: free and used extent chains plus a scanning controller
// depends on ffpa_pkg, ffpa_chain
//
// usage:
//   request channel: in_valid/in_stall with op, request_bytes, release_address.
//   response channel: out_valid/out_stall with grant_address and status.
//   config port: cfg_we, cfg_index (0 first page, 1 end page), cfg_data.
// one request is processed at a time. a release scans the used chain and
// then the free chain, an allocate only the free chain, one entry per cycle
// through a shared read index, then issues shift/insert/update commands that
// all cells apply in parallel; a release that merges with both neighbours
// adds a second update. the response sits in an output register; a new
// request is taken as soon as the response is loaded, even while the receiver
// stalls it, but the next response waits until the previous one is taken.
// reset clears counts, the ready flag and the handshakes; cell contents are
// undefined until written and never read beyond the counts.
// the free list is built from the heap bounds on the first nonzero allocate.
module first_fit_page_allocator
	import ffpa_pkg::*;
#(
	parameter int unsigned LIST_ENTRIES = LIST_ENTRIES_DEF,
	parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] request_bytes,
	input  logic [31:0] release_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] grant_address,
	output logic [2:0]  status,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [20:0] cfg_data
);

	localparam int unsigned IDX_W = $clog2(LIST_ENTRIES);
	localparam int unsigned CNT_W = $clog2(LIST_ENTRIES + 1);
	localparam int unsigned SH    = $clog2(PAGE_BYTES);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_ENTRIES);

	logic [19:0] heap_first_q;
	logic [20:0] heap_end_q;
	logic        ready_q;
	logic [CNT_W-1:0] free_cnt_q, used_cnt_q;

	state_t state_q, state_d;
	logic   is_rel_q;
	logic [32:0] pages_q;
	logic [31:0] rel_addr_q;
	logic [CNT_W-1:0] idx_q;
	logic   phase_q; // 0 used scan, 1 free scan
	logic   hit_q;
	logic [CNT_W-1:0] ui_q, fi_q;
	extent_t blk_q, prev_q, cur_q;
	logic   have_prev_q;
	logic [31:0] res_addr_q;
	logic [2:0]  res_st_q;
	logic [31:0] out_addr_q;
	logic [2:0]  out_st_q;
	logic        out_valid_q;

	chain_cmd_t fcmd, ucmd;
	extent_t    f_rd, u_rd;

	// both-merge needs a second update of the previous entry after removal
	logic fix_prev_q;
	extent_t fix_ext_q;
	logic [CNT_W-1:0] fix_idx_q;
	chain_cmd_t fcmd_fix;
	chain_cmd_t fcmd_eff;

	ffpa_chain #(.ENTRIES(LIST_ENTRIES)) u_free (
		.clk(clk), .cmd(fcmd_eff), .rd_idx(idx_q[IDX_W-1:0]), .rd_ext(f_rd));
	ffpa_chain #(.ENTRIES(LIST_ENTRIES)) u_used (
		.clk(clk), .cmd(ucmd), .rd_idx(idx_q[IDX_W-1:0]), .rd_ext(u_rd));

	logic take;
	assign in_stall = (state_q != S_IDLE);
	assign take = in_valid && !in_stall;

	// rounded page count of the request
	logic [32:0] pages_in;
	assign pages_in = ({1'b0, request_bytes} + 33'(PAGE_BYTES - 1)) >> SH;

	// release address match; page address wraps at 32 bits
	logic [31:0] u_addr;
	assign u_addr = 32'({11'd0, u_rd.start} << SH);

	logic scan_end;
	assign scan_end = phase_q ? (idx_q >= free_cnt_q) : (idx_q >= used_cnt_q);

	// decision signals evaluated in S_DECIDE
	logic [21:0] prev_end, blk_end;
	logic merge_prev, merge_next, both;
	assign prev_end = {1'b0, prev_q.start} + {1'b0, prev_q.len};
	assign blk_end  = {1'b0, blk_q.start} + {1'b0, blk_q.len};
	assign merge_prev = have_prev_q && (prev_end == {1'b0, blk_q.start});
	assign both = merge_prev && (fi_q < free_cnt_q)
		&& ((prev_end + {1'b0, blk_q.len}) == {1'b0, cur_q.start});
	assign merge_next = (fi_q < free_cnt_q) && (blk_end == {1'b0, cur_q.start});

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (take) state_d = S_SCAN;
			S_SCAN:   if (hit_q || scan_end) state_d = S_DECIDE;
			S_DECIDE: state_d = S_OUT;
			S_OUT:    if (!out_valid_q) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		fcmd = '{kind: CMD_NONE, idx: '0, ext: '0};
		ucmd = '{kind: CMD_NONE, idx: '0, ext: '0};
		if (state_q == S_IDLE && take && op == OP_ALLOC && request_bytes != '0 && !ready_q) begin
			fcmd.kind = CMD_INIT;
			fcmd.ext.start = {1'b0, heap_first_q};
			fcmd.ext.len = heap_end_q - {1'b0, heap_first_q};
		end
		if (state_q == S_DECIDE) begin
			if (!is_rel_q) begin
				if (hit_q && res_st_q == ST_DONE && used_cnt_q < FULL) begin
					ucmd.kind = CMD_APPEND;
					ucmd.idx = 13'(used_cnt_q);
					ucmd.ext.start = cur_q.start;
					ucmd.ext.len = LEN_W'(pages_q);
					fcmd.idx = 13'(fi_q);
					if ({12'd0, cur_q.len} > pages_q) begin
						fcmd.kind = CMD_UPDATE;
						fcmd.ext.start = cur_q.start + PAGE_W'(pages_q);
						fcmd.ext.len = cur_q.len - LEN_W'(pages_q);
					end else begin
						fcmd.kind = CMD_REMOVE;
					end
				end
			end else if (hit_q) begin
				if (merge_prev) begin
					if (both) begin
						fcmd.kind = CMD_REMOVE;
						fcmd.idx = 13'(fi_q);
					end else begin
						fcmd.kind = CMD_UPDATE;
						fcmd.idx = 13'(fi_q - 1'b1);
						fcmd.ext.start = prev_q.start;
						fcmd.ext.len = prev_q.len + blk_q.len;
					end
				end else if (merge_next) begin
					fcmd.kind = CMD_UPDATE;
					fcmd.idx = 13'(fi_q);
					fcmd.ext.start = blk_q.start;
					fcmd.ext.len = cur_q.len + blk_q.len;
				end else if (free_cnt_q < FULL) begin
					fcmd.kind = CMD_INSERT;
					fcmd.idx = 13'(fi_q);
					fcmd.ext = blk_q;
				end
				if (merge_prev || merge_next || free_cnt_q < FULL) begin
					ucmd.kind = CMD_REMOVE;
					ucmd.idx = 13'(ui_q);
				end
			end
		end
	end

	// fix cycle falls in S_OUT, which issues no command of its own
	always_comb begin
		fcmd_fix = '{kind: CMD_UPDATE, idx: 13'(fix_idx_q), ext: fix_ext_q};
		fcmd_eff = fix_prev_q ? fcmd_fix : fcmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_first_q <= '0;
			heap_end_q   <= 21'h100000;
			ready_q      <= 1'b0;
			free_cnt_q   <= '0;
			used_cnt_q   <= '0;
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			fix_prev_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			fix_prev_q <= (state_q == S_DECIDE) && is_rel_q && hit_q && both;
			if (cfg_we) begin
				if (cfg_index == CFG_FIRST) heap_first_q <= cfg_data[19:0];
				else heap_end_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (fcmd.kind == CMD_INIT) begin
				ready_q <= 1'b1;
				free_cnt_q <= (heap_end_q > {1'b0, heap_first_q}) ? CNT_W'(1) : '0;
			end
			if (state_q == S_DECIDE) begin
				if (!is_rel_q) begin
					if (hit_q && res_st_q == ST_DONE && used_cnt_q < FULL) begin
						used_cnt_q <= used_cnt_q + 1'b1;
						if (fcmd.kind == CMD_REMOVE) free_cnt_q <= free_cnt_q - 1'b1;
					end
				end else if (hit_q) begin
					if (both) begin
						free_cnt_q <= free_cnt_q - 1'b1;
					end else if (fcmd.kind == CMD_INSERT) begin
						free_cnt_q <= free_cnt_q + 1'b1;
					end
					if (ucmd.kind == CMD_REMOVE) used_cnt_q <= used_cnt_q - 1'b1;
				end
			end
			if (state_q == S_OUT && !out_valid_q) out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		fix_idx_q <= fi_q - 1'b1;
		fix_ext_q.start <= prev_q.start;
		fix_ext_q.len <= prev_q.len + blk_q.len + cur_q.len;
		if (state_q == S_IDLE && take) begin
			is_rel_q   <= (op == OP_RELEASE);
			pages_q    <= pages_in;
			rel_addr_q <= release_address;
			idx_q      <= '0;
			phase_q    <= (op == OP_ALLOC);
			have_prev_q <= 1'b0;
			res_addr_q <= '0;
			// zero size skips the scan
			hit_q      <= (op == OP_ALLOC && request_bytes == '0);
			res_st_q   <= (op == OP_ALLOC && request_bytes == '0) ? ST_ZERO : ST_DONE;
		end
		if (state_q == S_SCAN && !hit_q) begin
			if (!phase_q) begin
				if (scan_end) begin
					res_st_q <= ST_UNKNOWN;
				end else if (u_addr == rel_addr_q) begin
					blk_q <= u_rd;
					ui_q <= idx_q;
					phase_q <= 1'b1;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end else if (!is_rel_q) begin
				if (scan_end) begin
					res_st_q <= ST_NOFIT;
				end else if ({12'd0, f_rd.len} >= pages_q) begin
					hit_q <= 1'b1;
					cur_q <= f_rd;
					fi_q <= idx_q;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end else begin
				if (scan_end || f_rd.start > blk_q.start) begin
					hit_q <= 1'b1;
					cur_q <= f_rd;
					fi_q <= idx_q;
				end else begin
					prev_q <= f_rd;
					have_prev_q <= 1'b1;
					idx_q <= idx_q + 1'b1;
				end
			end
		end
		if (state_q == S_DECIDE && res_st_q == ST_DONE) begin
			if (!is_rel_q) begin
				if (used_cnt_q >= FULL) res_st_q <= ST_FULL;
				else res_addr_q <= 32'({11'd0, cur_q.start} << SH);
			end else if (!(merge_prev || merge_next || free_cnt_q < FULL)) begin
				res_st_q <= ST_FULL;
			end
		end
		if (state_q == S_OUT && !out_valid_q) begin
			out_addr_q <= res_addr_q;
			out_st_q   <= res_st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign grant_address = out_addr_q;
	assign status = out_st_q;

endmodule

>>> sv/ffpa_checker.sv
// port-level checker for the first-fit page allocator
// depends on ffpa_pkg and first_fit_page_allocator_defines.svh
`include "first_fit_page_allocator_defines.svh"
module ffpa_checker
	import ffpa_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] grant_address,
	input logic [2:0]  status
);

	`FFPA_ASSERT_IMP(a_status_range, clk, arst_n, out_valid, status <= 3'(ST_FULL))
	`FFPA_ASSERT_IMP(a_no_grant_on_error, clk, arst_n,
		out_valid && status != 3'(ST_DONE), grant_address == '0)
	`FFPA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`FFPA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(status) && $stable(grant_address))

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.grant_address(grant_address), .status(status)
);

>>> tb/tb.sv
// self-checking testbench for first_fit_page_allocator: random and directed requests,
// predicted against an in-bench model of the free and used extent lists
// depends on ffpa_pkg and the allocator rtl
module tb;
	import ffpa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ENTRIES = 64;
	localparam int unsigned PAGE    = 4096;
	localparam int unsigned HEAP_LO = 16;
	localparam int unsigned HEAP_HI = 2064;
	localparam int          STALL_LIMIT = 5000;

	typedef struct packed {
		op_t         op;
		logic [31:0] bytes;
		logic [31:0] addr;
	} request_t;

	typedef struct packed {
		logic [31:0] grant;
		status_t     st;
	} response_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = 1'b0;
	logic [31:0] request_bytes = '0;
	logic [31:0] release_address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] grant_address;
	logic [2:0]  status;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_FIRST;
	logic [20:0] cfg_data = '0;

	first_fit_page_allocator DUT (.*);

	// allocator shadow state
	int unsigned free_start[ENTRIES];
	int unsigned free_len[ENTRIES];
	int unsigned free_n;
	int unsigned used_start[ENTRIES];
	int unsigned used_len[ENTRIES];
	int unsigned used_n;
	bit          heap_built;
	int unsigned bound_lo;
	int unsigned bound_hi;

	request_t  pending_reqs[$];
	response_t expected_resp[$];
	int        errors;
	int        idle_cycles;
	int        n_requests;
	int        n_responses;
	int        status_seen[5];
	int        send_idle_pct;
	int        recv_stall_pct;
	bit        req_taken;
	bit        gen_done;

	initial forever #4 clk = ~clk;

	function automatic logic [31:0] page_to_addr(int unsigned pg);
		logic [63:0] a;
		a = 64'(pg) * 64'(PAGE);
		return a[31:0];
	endfunction

	function automatic response_t alloc_pages(logic [31:0] bytes);
		response_t r;
		int unsigned pages;
		int unsigned i;
		r.grant = '0;
		if (bytes == 0) begin
			r.st = ST_ZERO;
			return r;
		end
		if (!heap_built) begin
			free_n = 0;
			if (bound_hi > bound_lo) begin
				free_start[0] = bound_lo;
				free_len[0] = bound_hi - bound_lo;
				free_n = 1;
			end
			heap_built = 1;
		end
		pages = 32'((64'(bytes) + 64'(PAGE) - 64'd1) / 64'(PAGE));
		for (i = 0; i < free_n; i++)
			if (free_len[i] >= pages) break;
		if (i >= free_n) begin
			r.st = ST_NOFIT;
			return r;
		end
		if (used_n >= ENTRIES) begin
			r.st = ST_FULL;
			return r;
		end
		used_start[used_n] = free_start[i];
		used_len[used_n] = pages;
		used_n++;
		r.grant = page_to_addr(free_start[i]);
		r.st = ST_DONE;
		if (free_len[i] > pages) begin
			free_len[i] -= pages;
			free_start[i] += pages;
		end else begin
			free_n--;
			for (int k = i; k < free_n; k++) begin
				free_start[k] = free_start[k+1];
				free_len[k] = free_len[k+1];
			end
		end
		return r;
	endfunction

	function automatic response_t release_block(logic [31:0] addr);
		response_t r;
		int unsigned i, j, bs, bl;
		r.grant = '0;
		for (i = 0; i < used_n; i++)
			if (page_to_addr(used_start[i]) == addr) break;
		if (i >= used_n) begin
			r.st = ST_UNKNOWN;
			return r;
		end
		bs = used_start[i];
		bl = used_len[i];
		for (j = 0; j < free_n; j++)
			if (free_start[j] > bs) break;
		if (j > 0 && free_start[j-1] + free_len[j-1] == bs) begin
			free_len[j-1] += bl;
			// bridge into the next extent only when there is one
			if (j < free_n && free_start[j-1] + free_len[j-1] == free_start[j]) begin
				free_len[j-1] += free_len[j];
				free_n--;
				for (int k = j; k < free_n; k++) begin
					free_start[k] = free_start[k+1];
					free_len[k] = free_len[k+1];
				end
			end
		end else if (j < free_n && bs + bl == free_start[j]) begin
			free_start[j] = bs;
			free_len[j] += bl;
		end else begin
			if (free_n >= ENTRIES) begin
				r.st = ST_FULL;
				return r;
			end
			for (int k = free_n; k > j; k--) begin
				free_start[k] = free_start[k-1];
				free_len[k] = free_len[k-1];
			end
			free_start[j] = bs;
			free_len[j] = bl;
			free_n++;
		end
		used_n--;
		for (int k = i; k < used_n; k++) begin
			used_start[k] = used_start[k+1];
			used_len[k] = used_len[k+1];
		end
		r.st = ST_DONE;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	// request and response sampling, shadow update, watchdog
	always @(posedge clk) begin
		response_t want;
		req_taken = 0;
		if (arst_n) begin
			idle_cycles++;
			if (in_valid && !in_stall) begin
				req_taken = 1;
				idle_cycles = 0;
				n_requests++;
				if (op == OP_ALLOC)
					expected_resp.push_back(alloc_pages(request_bytes));
				else
					expected_resp.push_back(release_block(release_address));
			end
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				n_responses++;
				if (expected_resp.size() == 0) begin
					report_mismatch("unexpected response", grant_address, '0);
				end else begin
					want = expected_resp.pop_front();
					if (status <= 4) status_seen[status]++;
					if (status != want.st)
						report_mismatch("status", 32'(status), 32'(want.st));
					if (grant_address != want.grant)
						report_mismatch("grant_address", grant_address, want.grant);
				end
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("FAIL first_fit_page_allocator");
				$finish;
			end
		end
	end

	// request driver and response back-pressure
	always @(negedge clk) begin
		request_t nxt;
		if (arst_n) begin
			if (!in_valid || req_taken) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_reqs.pop_front();
					in_valid <= 1'b1;
					op <= nxt.op;
					request_bytes <= nxt.bytes;
					release_address <= nxt.addr;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic push_req(op_t o, logic [31:0] b, logic [31:0] a);
		request_t r;
		r.op = o;
		r.bytes = b;
		r.addr = a;
		pending_reqs.push_back(r);
	endtask

	task automatic write_reg(logic idx, logic [20:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_FIRST) bound_lo = 32'(val[19:0]);
		else bound_hi = 32'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || expected_resp.size() != 0)
			@(negedge clk);
		// let the scan settle before touching the registers
		repeat (300) @(negedge clk);
	endtask

	function automatic request_t random_req();
		request_t r;
		int unsigned pick;
		pick = $urandom_range(99);
		r.bytes = $urandom();
		r.addr = $urandom();
		r.op = OP_ALLOC;
		if (pick < 45) begin
			r.bytes = $urandom_range(5 * PAGE, 1);
		end else if (pick < 50) begin
			// full-range size, usually too big to fit
		end else if (pick < 53) begin
			r.bytes = '0;
		end else if (pick < 93 && used_n != 0) begin
			r.op = OP_RELEASE;
			r.addr = page_to_addr(used_start[$urandom_range(used_n - 1)]);
		end else begin
			r.op = OP_RELEASE;
		end
		return r;
	endfunction

	task automatic run_random(int count, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; ) begin
			@(negedge clk);
			if (pending_reqs.size() < 2) begin
				pending_reqs.push_back(random_req());
				n++;
			end
		end
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		n_requests = 0;
		n_responses = 0;
		free_n = 0;
		used_n = 0;
		heap_built = 0;
		bound_lo = 0;
		bound_hi = 1048576;
		send_idle_pct = 20;
		recv_stall_pct = 59;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// before the heap exists: unknown release, zero size does not build it
		push_req(OP_RELEASE, '0, '0);
		push_req(OP_ALLOC, '0, '1);
		drain();
		write_reg(CFG_FIRST, 21'd1048575);
		write_reg(CFG_END, 21'd1048576);
		write_reg(CFG_FIRST, 21'(HEAP_LO));
		write_reg(CFG_END, 21'(HEAP_HI));

		push_req(OP_ALLOC, 32'd1, '0);
		push_req(OP_ALLOC, 32'd4096, '0);
		push_req(OP_ALLOC, 32'd4097, '0);
		push_req(OP_ALLOC, 32'hFFFF_FFFF, '0);
		push_req(OP_RELEASE, '1, 32'h0001_0000);
		// merge with next, merge with both sides; the release above was a lone insert
		push_req(OP_RELEASE, '0, 32'h0001_2000);
		push_req(OP_RELEASE, '0, 32'h0001_1000);
		push_req(OP_RELEASE, '0, 32'h0001_0000);
		push_req(OP_RELEASE, '0, 32'hFFFF_FFFF);
		// take the whole heap so the extent is removed, then give it back
		push_req(OP_ALLOC, 32'((HEAP_HI - HEAP_LO) * PAGE), '0);
		push_req(OP_ALLOC, 32'd1, '0);
		push_req(OP_RELEASE, '0, 32'(HEAP_LO * PAGE));
		push_req(OP_ALLOC, 32'((HEAP_HI - HEAP_LO) * PAGE + 1), '0);
		drain();

		run_random(320, 20, 59);
		drain();
		// bounds are latched at the first allocate, these must change nothing
		write_reg(CFG_FIRST, 21'd0);
		write_reg(CFG_END, 21'd0);
		run_random(320, 59, 20);
		drain();
		write_reg(CFG_FIRST, 21'd1048575);
		write_reg(CFG_END, 21'd1048576);
		run_random(320, 0, 0);
		drain();

		$display("covered %0d requests / %0d responses: done %0d, zero %0d, no fit %0d,",
			n_requests, n_responses, status_seen[0], status_seen[1], status_seen[2]);
		$display("unknown address %0d, table full %0d", status_seen[3], status_seen[4]);
		if (errors == 0 && expected_resp.size() == 0) begin
			$display("PASS first_fit_page_allocator");
		end else begin
			$display("FAIL first_fit_page_allocator");
		end
		$finish;
	end
endmodule
